// File: sv/humidity_temp_frame_check_convert_top_macros.svh
// Assertion macros for the frame check and convert block.
// Each macro expects signals named clock and reset in the scope of use.
`ifndef HUMIDITY_TEMP_FRAME_CHECK_CONVERT_TOP_MACROS_SVH
`define HUMIDITY_TEMP_FRAME_CHECK_CONVERT_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge outside reset
`define HTFCC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Implication checked in the next cycle
`define HTFCC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define HTFCC_ASSERT(lbl, prop, msg)
`define HTFCC_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// File: sv/htfcc_pkg.sv
package htfcc_pkg;

   // Field widths
   localparam int RAW_W       = 16;
   localparam int CRC_W       = 8;
   localparam int VALUE_W     = 18;
   localparam int STATUS_BITS = 2;

   // Arithmetic widths
   localparam int GAIN_W = 18;
   localparam int PROD_W = GAIN_W + RAW_W;
   localparam int NUM_W  = PROD_W + 1;
   localparam int FRAC_W = 16;
   localparam int QUOT_W = NUM_W - FRAC_W;

   // CRC-8, x^8+x^5+x^4+1, MSB first
   localparam logic [CRC_W-1:0] CRC_POLY = 8'h31;
   localparam logic [CRC_W-1:0] CRC_INIT = 8'h00;

   // Conversion gains (milli-units per full scale) and offsets scaled by 2^16
   localparam logic [GAIN_W-1:0] TEMP_GAIN   = 18'd175720;
   localparam logic [GAIN_W-1:0] HUM_GAIN    = 18'd125000;
   localparam logic [NUM_W-1:0]  TEMP_OFFSET = 35'd3070361600;
   localparam logic [NUM_W-1:0]  HUM_OFFSET  = 35'd393216000;

   // Status codes
   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_CRC_ERR = 1'b1;

   typedef enum logic {
      KIND_TEMP = 1'b0,
      KIND_HUM  = 1'b1
   } kind_type;

   // Stage 1 to stage 2 transaction
   typedef struct packed {
      logic             valid;
      kind_type         kind;
      logic [RAW_W-1:0] word;
      logic [CRC_W-1:0] rcrc;
      logic [CRC_W-1:0] crc_hi;
   } s1_type;

   // Stage 2 to stage 3 transaction
   typedef struct packed {
      logic              valid;
      kind_type          kind;
      logic              crc_ok;
      logic [PROD_W-1:0] prod;
   } s2_type;

   // Advance a CRC-8 over one data byte
   function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                 input logic [CRC_W-1:0] data);
      logic [CRC_W-1:0] c;
      c = crc ^ data;
      for (int i = 0; i < CRC_W; i++) begin
         if (c[CRC_W-1]) begin
            c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[CRC_W-2:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// File: sv/htfcc_crc_stage.sv
module htfcc_crc_stage (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   input  logic                                  in_kind,
   input  logic [htfcc_pkg::RAW_W-1:0]           in_word,
   input  logic [htfcc_pkg::CRC_W-1:0]           in_rcrc,
   output htfcc_pkg::s1_type                     out_s1
);
   import htfcc_pkg::*;

   s1_type s1_ff;
   s1_type s1_in;

   // Run the CRC over the high byte
   always_comb begin
      s1_in.valid  = in_valid;
      s1_in.kind   = kind_type'(in_kind);
      s1_in.word   = in_word;
      s1_in.rcrc   = in_rcrc;
      s1_in.crc_hi = crc_byte(CRC_INIT, in_word[RAW_W-1:CRC_W]);
   end

   // Hold the transaction; clear it on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= '0;
      end else begin
         s1_ff <= s1_in;
      end
   end

   assign out_s1 = s1_ff;

endmodule

// File: sv/htfcc_mul_stage.sv
module htfcc_mul_stage (
   input  logic              clock,
   input  logic              reset,
   input  htfcc_pkg::s1_type in_s1,
   output htfcc_pkg::s2_type out_s2
);
   import htfcc_pkg::*;

   s2_type            s2_ff;
   s2_type            s2_in;
   logic [CRC_W-1:0]  crc_full;
   logic [GAIN_W-1:0] gain;
   logic [RAW_W-1:0]  mag;

   // Finish the CRC over the low byte, scale the word with status bits cleared
   always_comb begin
      crc_full = crc_byte(in_s1.crc_hi, in_s1.word[CRC_W-1:0]);
      gain     = (in_s1.kind == KIND_TEMP) ? TEMP_GAIN : HUM_GAIN;
      mag      = {in_s1.word[RAW_W-1:STATUS_BITS], {STATUS_BITS{1'b0}}};

      s2_in.valid  = in_s1.valid;
      s2_in.kind   = in_s1.kind;
      s2_in.crc_ok = (crc_full == in_s1.rcrc);
      s2_in.prod   = PROD_W'(gain) * PROD_W'(mag);
   end

   // Hold the transaction; clear it on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ff <= '0;
      end else begin
         s2_ff <= s2_in;
      end
   end

   assign out_s2 = s2_ff;

endmodule

// File: sv/htfcc_conv_stage.sv
module htfcc_conv_stage (
   input  logic                               clock,
   input  logic                               reset,
   input  htfcc_pkg::s2_type                  in_s2,
   output logic                               out_strobe,
   output logic signed [htfcc_pkg::VALUE_W-1:0] out_value,
   output logic                               out_status
);
   import htfcc_pkg::*;

   logic                      strobe_ff;
   logic                      strobe_in;
   logic signed [VALUE_W-1:0] value_ff;
   logic signed [VALUE_W-1:0] value_in;
   logic                      status_ff;
   logic                      status_in;
   logic [NUM_W-1:0]          num;
   logic [QUOT_W-1:0]         quot;

   // Subtract offset, divide by 2^16 truncating toward zero, zero the value and flag status on CRC error
   always_comb begin
      num = {1'b0, in_s2.prod} - ((in_s2.kind == KIND_TEMP) ? TEMP_OFFSET : HUM_OFFSET);
      quot = num[NUM_W-1:FRAC_W];
      if (num[NUM_W-1] && (num[FRAC_W-1:0] != '0)) begin
         quot = quot + QUOT_W'(1);
      end

      strobe_in = in_s2.valid;
      if (in_s2.crc_ok) begin
         value_in  = quot[VALUE_W-1:0];
         status_in = STATUS_OK;
      end else begin
         value_in  = '0;
         status_in = STATUS_CRC_ERR;
      end
   end

   // Register the result; strobe is reset
   always_ff @(posedge clock) begin
      value_ff  <= value_in;
      status_ff <= status_in;
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= strobe_in;
      end
   end

   assign out_strobe = strobe_ff;
   assign out_value  = value_ff;
   assign out_status = status_ff;

endmodule

// File: sv/humidity_temp_frame_check_convert_top.sv
// Throughput: one transaction per cycle while busy is low; each accepted transaction
// passes in order through the three register stages
// (high-byte CRC, low-byte CRC plus multiply, offset and scale).
// Reset: synchronous, clears all stage valid bits; busy is high during reset
// and in the cycle after it, and low otherwise, since results cannot stall.
`include "humidity_temp_frame_check_convert_top_macros.svh"

module humidity_temp_frame_check_convert_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic                                 req_type,
   input  logic [htfcc_pkg::RAW_W-1:0]          req_raw_data,
   input  logic [htfcc_pkg::CRC_W-1:0]          req_received_crc,
   output logic                                 rsp_strobe,
   output logic signed [htfcc_pkg::VALUE_W-1:0] rsp_value_milli,
   output logic                                 rsp_status
);
   import htfcc_pkg::*;

   logic   busy_ff;
   logic   accept;
   s1_type s1;
   s2_type s2;

   // Hold off transactions while coming out of reset
   always_ff @(posedge clock) begin
      busy_ff <= reset;
   end

   assign busy   = busy_ff | reset;
   assign accept = start & ~busy;

   htfcc_crc_stage u_crc (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .in_kind  (req_type),
      .in_word  (req_raw_data),
      .in_rcrc  (req_received_crc),
      .out_s1   (s1)
   );

   htfcc_mul_stage u_mul (
      .clock  (clock),
      .reset  (reset),
      .in_s1  (s1),
      .out_s2 (s2)
   );

   htfcc_conv_stage u_conv (
      .clock      (clock),
      .reset      (reset),
      .in_s2      (s2),
      .out_strobe (rsp_strobe),
      .out_value  (rsp_value_milli),
      .out_status (rsp_status)
   );

   `HTFCC_ASSERT(a_result_follows, accept |-> ##3 rsp_strobe, "accepted transaction lost")
   `HTFCC_ASSERT(a_no_spurious, rsp_strobe |-> $past(accept, 3), "result without transaction")
   `HTFCC_ASSERT(a_err_zero, rsp_strobe & rsp_status |-> rsp_value_milli == '0, "error value set")
   `HTFCC_ASSERT_NEXT(a_stage_order, s1.valid, s2.valid, "stage valid dropped")

endmodule

// File: verif/testbench.sv
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import htfcc_pkg::*;

   // Conversion constants in milli-units; the offsets are applied after scaling by 2^16
   localparam longint TEMP_SPAN_MILLI   = 175720;
   localparam longint TEMP_OFFSET_MILLI = 46850;
   localparam longint HUM_SPAN_MILLI    = 125000;
   localparam longint HUM_OFFSET_MILLI  = 6000;
   localparam longint FULL_SCALE        = 65536;
   localparam int     RANDOM_READINGS   = 1450;
   localparam int     CYCLE_LIMIT       = 300000;
   localparam int     DRAIN_CYCLES      = 8;

   typedef struct {
      kind_type          kind;
      logic [RAW_W-1:0]  word;
      logic [CRC_W-1:0]  rcrc;
      int unsigned       gap;
   } reading_type;

   typedef struct {
      logic signed [VALUE_W-1:0] value;
      logic                      status;
   } conversion_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic                      req_type = 1'b0;
   logic [RAW_W-1:0]          req_raw_data = '0;
   logic [CRC_W-1:0]          req_received_crc = '0;
   logic                      rsp_strobe;
   logic signed [VALUE_W-1:0] rsp_value_milli;
   logic                      rsp_status;

   reading_type    readings_to_send[$];
   conversion_type expected_conversions[$];
   int             mismatch_count = 0;
   int             accepted_count = 0;
   int             total_readings = 0;
   int             cycle_count = 0;
   int             wait_left = -1;
   reading_type    next_reading;
   conversion_type want;

   humidity_temp_frame_check_convert_top DUT (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_type         (req_type),
      .req_raw_data     (req_raw_data),
      .req_received_crc (req_received_crc),
      .rsp_strobe       (rsp_strobe),
      .rsp_value_milli  (rsp_value_milli),
      .rsp_status       (rsp_status)
   );

   initial forever #10 clock = ~clock;

   // Bit-serial CRC-8 over the word, high bit first
   function automatic logic [CRC_W-1:0] frame_crc(input logic [RAW_W-1:0] word);
      logic [CRC_W-1:0] c;
      logic             fb;
      c = CRC_INIT;
      for (int i = RAW_W - 1; i >= 0; i--) begin
         fb = c[CRC_W-1] ^ word[i];
         c = {c[CRC_W-2:0], 1'b0};
         if (fb) begin
            c = c ^ CRC_POLY;
         end
      end
      return c;
   endfunction

   // Predict the converted value and status of one reading
   function automatic conversion_type convert_reading(input kind_type kind,
                                                      input logic [RAW_W-1:0] word,
                                                      input logic [CRC_W-1:0] rcrc);
      conversion_type   r;
      logic [RAW_W-1:0] level_bits;
      longint           level;
      longint           scaled;
      if (frame_crc(word) != rcrc) begin
         r.value = '0;
         r.status = STATUS_CRC_ERR;
         return r;
      end
      // Drop the two status bits before converting
      level_bits = (word >> STATUS_BITS) << STATUS_BITS;
      level = longint'(level_bits);
      if (kind == KIND_TEMP) begin
         scaled = TEMP_SPAN_MILLI * level - TEMP_OFFSET_MILLI * FULL_SCALE;
      end else begin
         scaled = HUM_SPAN_MILLI * level - HUM_OFFSET_MILLI * FULL_SCALE;
      end
      r.value = VALUE_W'(scaled / FULL_SCALE);
      r.status = STATUS_OK;
      return r;
   endfunction

   task automatic add_reading(input kind_type kind, input logic [RAW_W-1:0] word,
                              input logic [CRC_W-1:0] rcrc, input int unsigned gap);
      reading_type r;
      r.kind = kind;
      r.word = word;
      r.rcrc = rcrc;
      r.gap = gap;
      readings_to_send.push_back(r);
      total_readings++;
   endtask

   task automatic report_mismatch(input string msg);
      $display("%0t ns mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   // Stimulus: directed corners first, then mostly well-formed random readings
   initial begin
      logic [RAW_W-1:0] word;
      logic [CRC_W-1:0] rcrc;
      kind_type         kind;
      int unsigned      gap;
      bit               no_idle;
      add_reading(KIND_TEMP, 16'h0000, frame_crc(16'h0000), 0);
      add_reading(KIND_HUM,  16'h0000, frame_crc(16'h0000), 0);
      add_reading(KIND_TEMP, 16'hFFFF, frame_crc(16'hFFFF), 0);
      add_reading(KIND_HUM,  16'hFFFF, frame_crc(16'hFFFF), 0);
      add_reading(KIND_TEMP, 16'hFFFC, frame_crc(16'hFFFC), 1);
      add_reading(KIND_HUM,  16'hFFFC, frame_crc(16'hFFFC), 0);
      add_reading(KIND_TEMP, 16'h0003, frame_crc(16'h0003), 2);
      add_reading(KIND_HUM,  16'h0001, frame_crc(16'h0001), 0);
      add_reading(KIND_HUM,  16'h0002, frame_crc(16'h0002), 0);
      add_reading(KIND_TEMP, 16'h6664, frame_crc(16'h6664), 0);
      add_reading(KIND_HUM,  16'h7FFE, frame_crc(16'h7FFE), 0);
      add_reading(KIND_TEMP, 16'h8000, frame_crc(16'h8000), 0);
      add_reading(KIND_TEMP, 16'h0004, frame_crc(16'h0004), 0);
      // CRC mismatches: single-bit flips and gross errors, mixed with well-formed readings
      add_reading(KIND_TEMP, 16'h0000, frame_crc(16'h0000) ^ 8'h01, 0);
      add_reading(KIND_HUM,  16'hFFFF, frame_crc(16'hFFFF) ^ 8'h80, 0);
      add_reading(KIND_TEMP, 16'h1234, frame_crc(16'h1234) ^ 8'hFF, 0);
      add_reading(KIND_HUM,  16'hABCD, frame_crc(16'hABCD) ^ 8'h5A, 4);
      add_reading(KIND_HUM,  16'h5555, frame_crc(16'h5555), 3);
      add_reading(KIND_TEMP, 16'hAAAA, frame_crc(16'hAAAA), 15);
      add_reading(KIND_TEMP, 16'hAAAA, frame_crc(16'hAAAA) ^ 8'h10, 0);

      no_idle = 1'b0;
      for (int n = 0; n < RANDOM_READINGS; n++) begin
         // Alternate stretches of back-to-back traffic with random gaps
         if (n % 64 == 0) begin
            no_idle = ($urandom_range(0, 3) == 0);
         end
         kind = ($urandom_range(0, 1) == 0) ? KIND_TEMP : KIND_HUM;
         case ($urandom_range(0, 9))
            0: word = 16'h0000 | RAW_W'($urandom_range(0, 3));
            1: word = 16'hFFFC | RAW_W'($urandom_range(0, 3));
            default: word = RAW_W'($urandom);
         endcase
         rcrc = frame_crc(word);
         case ($urandom_range(0, 9))
            0: rcrc = CRC_W'($urandom);
            1: rcrc = rcrc ^ (CRC_W'(1) << $urandom_range(0, CRC_W - 1));
            default: ;
         endcase
         gap = no_idle ? 0 : $urandom_range(0, 15);
         add_reading(kind, word, rcrc, gap);
      end

      // Hold until every transaction is taken and every result is back
      wait (!reset);
      while (accepted_count != total_readings || expected_conversions.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

   // Hold reset from time zero, then release it
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end

   // Drive readings; hold the current one while busy, then advance after its gap
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         wait_left = -1;
      end else if (!(start && busy)) begin
         if (start) begin
            expected_conversions.push_back(
               convert_reading(kind_type'(req_type), req_raw_data, req_received_crc));
            accepted_count++;
         end
         if (readings_to_send.size() != 0) begin
            if (wait_left < 0) begin
               wait_left = readings_to_send[0].gap;
            end
            if (wait_left == 0) begin
               next_reading = readings_to_send.pop_front();
               req_type <= next_reading.kind;
               req_raw_data <= next_reading.word;
               req_received_crc <= next_reading.rcrc;
               start <= 1'b1;
               wait_left = -1;
            end else begin
               start <= 1'b0;
               wait_left--;
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Check each result against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_conversions.size() == 0) begin
            report_mismatch($sformatf("unexpected result value %0d status %0b",
                                      rsp_value_milli, rsp_status));
         end else begin
            want = expected_conversions.pop_front();
            if (rsp_value_milli !== want.value) begin
               report_mismatch($sformatf("value_milli %0d, predicted %0d",
                                         rsp_value_milli, want.value));
            end
            if (rsp_status !== want.status) begin
               report_mismatch($sformatf("status %0b, predicted %0b",
                                         rsp_status, want.status));
            end
         end
      end
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

endmodule

`default_nettype wire

// File: humidity_temp_frame_check_convert_top.f
+incdir+sv
sv/htfcc_pkg.sv
sv/htfcc_crc_stage.sv
sv/htfcc_mul_stage.sv
sv/htfcc_conv_stage.sv
sv/humidity_temp_frame_check_convert_top.sv
verif/testbench.sv
